// ----- rtl/core/ptt_pkg.sv -----
// ----------------------------------------------------------------------------
// Periodic timer table package
// Request, result, entry and state types, codes and defaults shared by the timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 16;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CHECK  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FIRED     = 3'd5,
    ST_NONE_DUE  = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] timer_key;
    logic [31:0] period;
    logic [63:0] now_tick;
  } req_t;

  typedef struct packed {
    logic [15:0] result_key;
    logic [2:0]  status;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [15:0] key;
    logic [31:0] period;
    logic [63:0] due;
  } entry_t;

endpackage

// ----- rtl/core/periodic_timer_table.sv -----
// ----------------------------------------------------------------------------
// Periodic timer table
// Insertion-ordered table of periodic timers with add, remove and check.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                 Handshake
//   --------  ----------------------  -------------------------------------
//   request   start, busy, request    taken at an edge with start & !busy
//   result    result_valid, result    one cycle per result, cannot stall
//
// One request is handled at a time; busy is high from the cycle after the
// request is taken until its last result is presented. The table lives in a
// single memory with one write port and one registered read port, so every
// scanned entry is read (S_SCAN_RD), then evaluated (S_SCAN_EV). An add
// or remove scans until its key is found or the entries run out; a remove
// then moves each entry above the gap down (S_SHIFT_RD, S_SHIFT_WR), and
// a check scans every entry. An unused command code is dropped with no result.
// Reset clears the entry count and the control state; the memory itself
// needs no clearing since only entries below the count are ever read.
// The receiver cannot stall, so results leave as soon as they are formed.
// ----------------------------------------------------------------------------
module periodic_timer_table #(
  parameter int TABLE_DEPTH = ptt_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ptt_pkg::req_t request,
  output logic          result_valid,
  output ptt_pkg::rsp_t result
);
  import ptt_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Table storage: one entry per timer, registered read.
  entry_t mem [TABLE_DEPTH];
  entry_t rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  state_e state, state_next;

  // Latched request fields.
  logic [1:0]  cmd;
  logic [15:0] key;
  logic [31:0] per;
  logic [63:0] now;

  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] count, count_next;

  // A fired key is held back until we know whether it is the final one.
  logic        pend_valid, pend_valid_next;
  logic [15:0] pend_key, pend_key_next;

  logic result_valid_next;
  rsp_t result_next;

  // Shared 64-bit adder and compare.
  logic        use_entry;
  logic [63:0] add_a;
  logic [31:0] add_b;
  logic [63:0] add_sum;
  logic        is_due;

  logic            scan_end;
  logic            key_match;
  logic [CNT_W:0]  idx_inc;
  logic            shift_end;

  assign busy = (state != S_IDLE);

  assign scan_end  = (idx >= count);
  assign key_match = (rd_data.key == key);
  assign idx_inc   = {1'b0, idx} + {{CNT_W{1'b0}}, 1'b1};
  assign shift_end = (idx_inc >= {1'b0, count});

  // During a check the entry's own due time is advanced; otherwise the
  // adder forms now plus the requested period.
  assign use_entry = (state == S_SCAN_EV) && (cmd == CMD_CHECK);
  assign add_a     = use_entry ? rd_data.due : now;
  assign add_b     = use_entry ? rd_data.period : per;
  assign add_sum   = add_a + {32'd0, add_b};
  assign is_due    = (now >= rd_data.due);

  always_comb begin
    rd_addr = idx[IDX_W-1:0];
    if (state == S_SHIFT_RD) begin
      rd_addr = idx_inc[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && (request.command inside {CMD_ADD, CMD_REMOVE, CMD_CHECK})) begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_next = scan_end ? S_IDLE : S_SCAN_EV;
      end
      S_SCAN_EV: begin
        state_next = S_SCAN_RD;
        if (key_match && cmd == CMD_ADD) begin
          state_next = S_IDLE;
        end else if (key_match && cmd == CMD_REMOVE) begin
          state_next = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        state_next = shift_end ? S_IDLE : S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        state_next = S_SHIFT_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Datapath, memory writes and results.
  always_comb begin
    idx_next          = idx;
    count_next        = count;
    pend_valid_next   = pend_valid;
    pend_key_next     = pend_key;
    result_valid_next = 1'b0;
    result_next       = '{result_key: key, status: ST_NONE_DUE, last: 1'b1};
    wr_en             = 1'b0;
    wr_addr           = idx[IDX_W-1:0];
    wr_data           = '{key: key, period: per, due: add_sum};

    case (state)
      S_IDLE: begin
        idx_next        = '0;
        pend_valid_next = 1'b0;
      end
      S_SCAN_RD: begin
        if (scan_end) begin
          result_valid_next = 1'b1;
          case (cmd)
            CMD_ADD: begin
              if (count < CNT_W'(TABLE_DEPTH)) begin
                wr_en              = 1'b1;
                wr_addr            = count[IDX_W-1:0];
                count_next         = count + {{(CNT_W-1){1'b0}}, 1'b1};
                result_next.status = ST_INSERTED;
              end else begin
                result_next.status = ST_FULL;
              end
            end
            CMD_REMOVE: begin
              result_next.status = ST_NOT_FOUND;
            end
            default: begin
              // End of a check: release the held key as the final result,
              // or report that nothing was due.
              if (pend_valid) begin
                result_next.result_key = pend_key;
                result_next.status     = ST_FIRED;
              end else begin
                result_next.result_key = 16'd0;
                result_next.status     = ST_NONE_DUE;
              end
              pend_valid_next = 1'b0;
            end
          endcase
        end
      end
      S_SCAN_EV: begin
        idx_next = idx_inc[CNT_W-1:0];
        case (cmd)
          CMD_ADD: begin
            if (key_match) begin
              wr_en              = 1'b1;
              result_valid_next  = 1'b1;
              result_next.status = ST_UPDATED;
            end
          end
          CMD_REMOVE: begin
            if (key_match) begin
              idx_next = idx;
            end
          end
          default: begin
            if (is_due) begin
              wr_en   = 1'b1;
              wr_data = '{key: rd_data.key, period: rd_data.period, due: add_sum};
              if (pend_valid) begin
                result_valid_next      = 1'b1;
                result_next.result_key = pend_key;
                result_next.status     = ST_FIRED;
                result_next.last       = 1'b0;
              end
              pend_valid_next = 1'b1;
              pend_key_next   = rd_data.key;
            end
          end
        endcase
      end
      S_SHIFT_RD: begin
        if (shift_end) begin
          count_next         = count - {{(CNT_W-1){1'b0}}, 1'b1};
          result_valid_next  = 1'b1;
          result_next.status = ST_REMOVED;
        end
      end
      S_SHIFT_WR: begin
        // Move the entry above down into the gap.
        wr_en    = 1'b1;
        wr_data  = rd_data;
        idx_next = idx_inc[CNT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      idx          <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      idx          <= idx_next;
      pend_valid   <= pend_valid_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_key <= pend_key_next;
    result   <= result_next;
    if (state == S_IDLE && start) begin
      cmd <= request.command;
      key <= request.timer_key;
      per <= request.period;
      now <= request.now_tick;
    end
  end

endmodule
